// ----- sv/brfc_pkg.sv -----
`default_nettype none
package brfc_pkg;

    localparam int Q_W    = 24;   // Q8.16 operand width
    localparam int SQ_W   = 32;   // x^2 in Q.16
    localparam int PROD_W = 56;   // shared multiplier product
    localparam int F_W    = 42;   // f(x) in Q.16
    localparam int WTOL_W = 24;
    localparam int RTOL_W = 32;
    localparam int ITER_W = 6;
    localparam int PASS_W = 7;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 2;

    localparam logic signed [F_W-1:0] F_CONST = 42'sd393216;  // 6 in Q.16

    localparam logic [IDX_W-1:0] CFG_WIDTH_TOL    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_RESIDUAL_TOL = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MAX_ITER     = 2'd2;

    localparam logic [WTOL_W-1:0] WTOL_RESET = 24'd66;
    localparam logic [RTOL_W-1:0] RTOL_RESET = 32'd66;
    localparam logic [ITER_W-1:0] ITER_RESET = 6'd30;

    localparam logic [1:0] REASON_RESIDUAL = 2'd0;
    localparam logic [1:0] REASON_WIDTH    = 2'd1;
    localparam logic [1:0] REASON_ITER     = 2'd2;

    typedef struct packed {
        logic                  done;
        logic signed [F_W-1:0] value;
    } cubic_result_t;

endpackage
`default_nettype wire

// ----- sv/brfc_in_if.sv -----
`default_nettype none
interface brfc_in_if;
    logic                valid;
    logic                ready;
    logic signed [23:0]  interval_low;
    logic signed [23:0]  interval_high;

    modport source (output valid, output interval_low, output interval_high, input ready);
    modport sink   (input valid, input interval_low, input interval_high, output ready);
endinterface
`default_nettype wire

// ----- sv/brfc_out_if.sv -----
`default_nettype none
interface brfc_out_if;
    logic                valid;
    logic                ready;
    logic signed [23:0]  root_estimate;
    logic [6:0]          passes_used;
    logic [1:0]          stop_reason;

    modport source (output valid, output root_estimate, output passes_used,
                    output stop_reason, input ready);
    modport sink   (input valid, input root_estimate, input passes_used,
                    input stop_reason, output ready);
endinterface
`default_nettype wire

// ----- sv/brfc_cubic.sv -----
`default_nettype none
module brfc_cubic (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic signed [brfc_pkg::Q_W-1:0] x,
    output brfc_pkg::cubic_result_t           result
);
    import brfc_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_SQ, PH_CU, PH_SUM} phase_t;

    phase_t                     phase_reg;
    logic signed [Q_W-1:0]      x_reg;
    logic signed [SQ_W-1:0]     sq_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [F_W-1:0]      f_reg;
    logic                       done_reg;

    logic signed [SQ_W-1:0]     mul_a;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [F_W-1:0]      cu_ext;
    logic signed [F_W-1:0]      sq8;
    logic signed [F_W-1:0]      x_ext;
    logic signed [F_W-1:0]      f_next;

    // One multiplier: x*x in the first step, floor(x^2)*x in the second
    always_comb
    begin
        if (phase_reg == PH_SQ)
            mul_a = {{(SQ_W-Q_W){x_reg[Q_W-1]}}, x_reg};
        else
            mul_a = prod_reg[SQ_W+15:16];
        mul_p = mul_a * x_reg;
    end

    always_comb
    begin
        cu_ext = {{(F_W-(PROD_W-16)){prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:16]};
        sq8    = {{(F_W-SQ_W-3){sq_reg[SQ_W-1]}}, sq_reg, 3'b000};
        x_ext  = {{(F_W-Q_W){x_reg[Q_W-1]}}, x_reg};
        f_next = cu_ext + sq8 + x_ext + (x_ext <<< 1) - F_CONST;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (start)
                        phase_reg <= PH_SQ;
                end
                PH_SQ:   phase_reg <= PH_CU;
                PH_CU:   phase_reg <= PH_SUM;
                PH_SUM:
                begin
                    phase_reg <= PH_IDLE;
                    done_reg  <= 1'b1;
                end
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
            x_reg <= x;
        if (phase_reg == PH_SQ || phase_reg == PH_CU)
            prod_reg <= mul_p;
        if (phase_reg == PH_CU)
            sq_reg <= prod_reg[SQ_W+15:16];
        if (phase_reg == PH_SUM)
            f_reg <= f_next;
    end

    assign result.done  = done_reg;
    assign result.value = f_reg;

endmodule
`default_nettype wire

// ----- sv/bisection_root_finder_cubic.sv -----
// Bisection root finder for f(x) = x^3 + 8x^2 + 3x - 6.
// req carries one interval (interval_low, interval_high) in signed Q8.16.
// rsp returns one word per interval: the last midpoint, the passes used
// and the stop reason (residual small, interval small, passes exhausted).
// cfg_we/cfg_index/cfg_data write width_tolerance (0), residual_tolerance
// (1) and max_iterations (2); write only while no interval is in flight.
// One evaluation of f runs on a single shared 32x24 multiplier
// (square, cube, sum). An interval first evaluates f(high), then each
// pass forms the midpoint and evaluates f(mid), and a finish step loads
// the word; up to 64 passes, 31 at the reset max_iterations of 30.
// The block takes one interval at a time; req.ready is high only when it
// is idle. A finished word sits in the output register, so the next
// interval may be accepted while rsp is stalled; a second finished word
// waits in the core until rsp drains.
// Reset restores the register defaults (66, 66, 30) and empties the block.
`default_nettype none
module bisection_root_finder_cubic (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    brfc_in_if.sink                            req,
    brfc_out_if.source                         rsp,
    input  wire logic                          cfg_we,
    input  wire logic [brfc_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [brfc_pkg::CFG_W-1:0]    cfg_data
);
    import brfc_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_WAIT_HI, S_MID, S_WAIT_MID, S_FINISH} state_t;

    state_t                 state_reg, state_next;
    logic [WTOL_W-1:0]      wtol_reg;
    logic [RTOL_W-1:0]      rtol_reg;
    logic [ITER_W-1:0]      max_iter_reg;

    logic signed [Q_W-1:0]  lo_reg, lo_next;
    logic signed [Q_W-1:0]  hi_reg, hi_next;
    logic signed [Q_W-1:0]  mid_reg, mid_next;
    logic [Q_W:0]           wid_reg, wid_next;
    logic [ITER_W-1:0]      pass_reg, pass_next;
    logic                   fhi_neg_reg, fhi_neg_next;
    logic                   fhi_zero_reg, fhi_zero_next;
    logic [1:0]             reason_reg, reason_next;

    logic                   out_valid_reg, out_valid_next;
    logic signed [Q_W-1:0]  out_root_reg, out_root_next;
    logic [PASS_W-1:0]      out_passes_reg, out_passes_next;
    logic [1:0]             out_reason_reg, out_reason_next;

    logic                   accept;
    logic                   cubic_start;
    logic signed [Q_W-1:0]  cubic_x;
    cubic_result_t          cubic_res;

    logic signed [Q_W:0]    sum;
    logic signed [Q_W:0]    diff;
    logic [F_W-1:0]         f_abs;
    logic                   f_neg;
    logic                   f_zero;
    logic                   res_small;
    logic                   wid_small;
    logic                   out_free;

    brfc_cubic u_cubic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cubic_start),
        .x      (cubic_x),
        .result (cubic_res)
    );

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        sum       = {lo_reg[Q_W-1], lo_reg} + {hi_reg[Q_W-1], hi_reg};
        diff      = {lo_reg[Q_W-1], lo_reg} - {hi_reg[Q_W-1], hi_reg};
        f_neg     = cubic_res.value[F_W-1];
        f_zero    = (cubic_res.value == '0);
        f_abs     = f_neg ? F_W'(-cubic_res.value) : F_W'(cubic_res.value);
        res_small = f_abs < {{(F_W-RTOL_W){1'b0}}, rtol_reg};
        wid_small = wid_reg < {1'b0, wtol_reg};
    end

    always_comb
    begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        wid_next        = wid_reg;
        pass_next       = pass_reg;
        fhi_neg_next    = fhi_neg_reg;
        fhi_zero_next   = fhi_zero_reg;
        reason_next     = reason_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_root_next   = out_root_reg;
        out_passes_next = out_passes_reg;
        out_reason_next = out_reason_reg;
        cubic_start     = 1'b0;
        cubic_x         = req.interval_high;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    lo_next     = req.interval_low;
                    hi_next     = req.interval_high;
                    pass_next   = '0;
                    cubic_start = 1'b1;
                    state_next  = S_WAIT_HI;
                end
            end
            S_WAIT_HI:
            begin
                if (cubic_res.done)
                begin
                    fhi_neg_next  = f_neg;
                    fhi_zero_next = f_zero;
                    state_next    = S_MID;
                end
            end
            S_MID:
            begin
                // floor((lo+hi)/2) and |lo-hi| for this pass
                mid_next    = sum[Q_W:1];
                wid_next    = diff[Q_W] ? (Q_W+1)'(-diff) : (Q_W+1)'(diff);
                cubic_x     = sum[Q_W:1];
                cubic_start = 1'b1;
                state_next  = S_WAIT_MID;
            end
            S_WAIT_MID:
            begin
                if (cubic_res.done)
                begin
                    if (res_small)
                    begin
                        reason_next = REASON_RESIDUAL;
                        state_next  = S_FINISH;
                    end
                    else if (wid_small)
                    begin
                        reason_next = REASON_WIDTH;
                        state_next  = S_FINISH;
                    end
                    else if (pass_reg == max_iter_reg)
                    begin
                        reason_next = REASON_ITER;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        // move high to mid when f(high) and f(mid) share a nonzero sign
                        if (!fhi_zero_reg && !f_zero && (fhi_neg_reg == f_neg))
                            hi_next = mid_reg;
                        else
                            lo_next = mid_reg;
                        pass_next  = pass_reg + ITER_W'(1);
                        state_next = S_MID;
                    end
                end
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_root_next   = mid_reg;
                    out_passes_next = {1'b0, pass_reg} + PASS_W'(1);
                    out_reason_next = reason_reg;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            out_root_reg   <= '0;
            out_passes_reg <= '0;
            out_reason_reg <= REASON_RESIDUAL;
            wtol_reg       <= WTOL_RESET;
            rtol_reg       <= RTOL_RESET;
            max_iter_reg   <= ITER_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            out_root_reg   <= out_root_next;
            out_passes_reg <= out_passes_next;
            out_reason_reg <= out_reason_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WIDTH_TOL:    wtol_reg     <= cfg_data[WTOL_W-1:0];
                    CFG_RESIDUAL_TOL: rtol_reg     <= cfg_data[RTOL_W-1:0];
                    CFG_MAX_ITER:     max_iter_reg <= cfg_data[ITER_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        wid_reg      <= wid_next;
        pass_reg     <= pass_next;
        fhi_neg_reg  <= fhi_neg_next;
        fhi_zero_reg <= fhi_zero_next;
        reason_reg   <= reason_next;
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.root_estimate = out_root_reg;
    assign rsp.passes_used   = out_passes_reg;
    assign rsp.stop_reason   = out_reason_reg;

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        cubic_res.done |-> (state_reg == S_WAIT_HI || state_reg == S_WAIT_MID))
        else $error("cubic result arrived outside a wait state");

    a_pass_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT_MID) |-> (pass_reg <= max_iter_reg))
        else $error("pass index beyond max_iterations");

    a_accept_starts_eval: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_WAIT_HI))
        else $error("accepted interval did not start f(high)");

    a_word_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_free) |=>
            (rsp.valid && rsp.passes_used != '0 && rsp.stop_reason <= REASON_ITER))
        else $error("finished word not loaded correctly");

endmodule
`default_nettype wire
